[hdl/hsa_pkg.sv]
// Shared types and constants for the handle slot allocator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package hsa_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int HANDLE_W     = 12;
    localparam int OBJ_W        = 64;
    localparam int LIMIT_W      = 13;
    localparam int HANDLE_SPACE = 4096;

    // Configuration register map.
    localparam int  APB_ADDR_W    = 3;
    localparam int  APB_DATA_W    = 32;
    localparam logic REG_SLOT_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_GET        = 2'd2,
        CMD_CLEAR      = 2'd3
    } hsa_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } hsa_status_t;

    // Input transaction.
    typedef struct packed {
        hsa_cmd_t              command;
        logic [HANDLE_W-1:0]   slot_index;
        logic [OBJ_W-1:0]      object_value;
    } hsa_req_t;

    // Result transaction.
    typedef struct packed {
        logic [HANDLE_W-1:0]   slot_out;
        logic [OBJ_W-1:0]      object_out;
        hsa_status_t           status;
    } hsa_rsp_t;

    // Write request into the object table.
    typedef struct packed {
        logic                  en;
        logic [HANDLE_W-1:0]   slot;
        logic [OBJ_W-1:0]      data;
    } hsa_tbl_wr_t;

    // Push request onto the free stack (address travels separately).
    typedef struct packed {
        logic                  en;
        logic [HANDLE_W-1:0]   data;
    } hsa_stk_wr_t;

endpackage

[hdl/hsa_obj_table.sv]
// Object table: one synchronous RAM of 64-bit references indexed by slot.
// Depends on hsa_pkg for the handle width and the write request struct.
`timescale 1ns / 1ps

module hsa_obj_table #(
    parameter int DEPTH = 4096
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [hsa_pkg::HANDLE_W-1:0] rd_slot,
    output logic [hsa_pkg::OBJ_W-1:0]    rd_data,
    input  hsa_pkg::hsa_tbl_wr_t        wr
);
    import hsa_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [OBJ_W-1:0] mem [DEPTH];
    logic [OBJ_W-1:0] rdata_reg;

    // Single write port, single registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.slot[ADDR_W-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_slot[ADDR_W-1:0]];
        end
    end

    assign rd_data = rdata_reg;

endmodule

[hdl/hsa_free_stack.sv]
// Free stack storage: a synchronous RAM of released slot handles.
// Depends on hsa_pkg for the handle width and the push request struct.
`timescale 1ns / 1ps

module hsa_free_stack #(
    parameter int DEPTH = 4096
) (
    input  logic                                    clk,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [hsa_pkg::HANDLE_W-1:0]             rd_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  hsa_pkg::hsa_stk_wr_t                    wr
);
    import hsa_pkg::*;

    logic [HANDLE_W-1:0] mem [DEPTH];
    logic [HANDLE_W-1:0] rdata_reg;

    // The entry at the top pointer is read every cycle; the caller uses the data only on a pop.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign rd_data = rdata_reg;

endmodule

[hdl/handle_slot_allocator_unit.sv]
// Top level of the handle slot allocator: control sequencer, counters, APB register.
// Depends on hsa_pkg, hsa_obj_table and hsa_free_stack.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive req and raise start; the transaction is taken at a
//   clock edge where start is high and busy is low. busy is high for exactly
//   one cycle after each accepted command.
//   Result channel: done pulses for one cycle with rsp holding slot_out,
//   object_out and status. The receiver cannot stall; it must take the result
//   in that cycle.
//   Sequence: the accepting edge starts the synchronous reads of the object
//   table and of the free-stack top; the next edge writes back, registers the
//   result and raises done.
//   Commands do not overlap: no new command is taken while busy, because of
//   the read-then-write sequence on the two single-port-per-direction RAMs.
//   A new command may be accepted in the same cycle that done is shown.
//   Configuration: slot_limit sits at byte address 0 of the APB port; write it
//   only while the block is idle.
//   Reset: rst_n clears the high-water mark, the free count and slot_limit
//   (to 4096). The RAM contents are not cleared and need no clearing pass:
//   only table entries below the high-water mark and stack entries below the free count are ever used.
module handle_slot_allocator_unit #(
    parameter int CAPACITY = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command and result channels.
    input  logic                            start,
    output logic                            busy,
    input  hsa_pkg::hsa_req_t               req,
    output logic                            done,
    output hsa_pkg::hsa_rsp_t               rsp,
    // APB configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hsa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hsa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hsa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import hsa_pkg::*;

    localparam int TBL_DEPTH = (CAPACITY < HANDLE_SPACE) ? CAPACITY : HANDLE_SPACE;
    localparam int FC_W      = $clog2(CAPACITY + 1);
    localparam int SA_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(TBL_DEPTH);
    localparam logic [FC_W-1:0]    FC_FULL   = FC_W'(CAPACITY);
    localparam logic [FC_W-1:0]    FC_ONE    = FC_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   hw_reg, hw_next;
    logic [FC_W-1:0]      fc_reg, fc_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    hsa_req_t             cmd_reg, cmd_next;
    logic                 done_reg, done_next;
    hsa_rsp_t             rsp_reg, rsp_next;

    logic                 accept;
    logic                 cfg_write;
    logic [LIMIT_W-1:0]   bump_lim;
    logic [FC_W-1:0]      fc_dec;
    logic [OBJ_W-1:0]     tbl_rdata;
    logic [HANDLE_W-1:0]  stk_rdata;
    hsa_tbl_wr_t          tbl_wr;
    hsa_stk_wr_t          stk_wr;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_write = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_SLOT_LIMIT);
    assign bump_lim  = (limit_reg < LIMIT_CAP) ? limit_reg : LIMIT_CAP;
    assign fc_dec    = fc_reg - FC_ONE;

    // State RAMs.
    hsa_obj_table #(
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk     (clk),
        .rd_en   (accept),
        .rd_slot (req.slot_index),
        .rd_data (tbl_rdata),
        .wr      (tbl_wr)
    );

    hsa_free_stack #(
        .DEPTH (CAPACITY)
    ) u_stack (
        .clk     (clk),
        .rd_addr (fc_dec[SA_W-1:0]),
        .rd_data (stk_rdata),
        .wr_addr (fc_reg[SA_W-1:0]),
        .wr      (stk_wr)
    );

    // Sequencer: latch the command, then decide and write back with the read data; APB writes update slot_limit.
    always_comb
    begin
        state_next = state_reg;
        hw_next    = hw_reg;
        fc_next    = fc_reg;
        limit_next = cfg_write ? pwdata[LIMIT_W-1:0] : limit_reg;
        cmd_next   = cmd_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        tbl_wr     = '{en: 1'b0, slot: cmd_reg.slot_index, data: '0};
        stk_wr     = '{en: 1'b0, data: cmd_reg.slot_index};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = req;
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                state_next          = ST_IDLE;
                done_next           = 1'b1;
                rsp_next.slot_out   = cmd_reg.slot_index;
                rsp_next.object_out = '0;
                rsp_next.status     = STAT_OK;
                case (cmd_reg.command)
                    CMD_REGISTER:
                    begin
                        if (fc_reg != '0)
                        begin
                            // Reuse the most recently freed slot.
                            fc_next           = fc_dec;
                            tbl_wr            = '{en: 1'b1, slot: stk_rdata,
                                                  data: cmd_reg.object_value};
                            rsp_next.slot_out = stk_rdata;
                        end
                        else if (hw_reg < bump_lim)
                        begin
                            // Hand out a fresh slot at the high-water mark.
                            hw_next           = hw_reg + LIMIT_W'(1);
                            tbl_wr            = '{en: 1'b1, slot: hw_reg[HANDLE_W-1:0],
                                                  data: cmd_reg.object_value};
                            rsp_next.slot_out = hw_reg[HANDLE_W-1:0];
                        end
                        else
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                    end
                    CMD_UNREGISTER:
                    begin
                        if ({1'b0, cmd_reg.slot_index} >= hw_reg)
                        begin
                            rsp_next.status = STAT_RANGE;
                        end
                        else
                        begin
                            tbl_wr = '{en: 1'b1, slot: cmd_reg.slot_index, data: '0};
                            // A push onto a full stack is dropped.
                            if (fc_reg < FC_FULL)
                            begin
                                stk_wr.en = 1'b1;
                                fc_next   = fc_reg + FC_ONE;
                            end
                        end
                    end
                    CMD_GET:
                    begin
                        if ({1'b0, cmd_reg.slot_index} >= hw_reg)
                        begin
                            rsp_next.status = STAT_RANGE;
                        end
                        else
                        begin
                            rsp_next.object_out = tbl_rdata;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        hw_next = '0;
                        fc_next = '0;
                    end
                    default:
                    begin
                        rsp_next.status = STAT_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters, slot_limit and the done register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hw_reg    <= '0;
            fc_reg    <= '0;
            limit_reg <= SLOT_LIMIT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hw_reg    <= hw_next;
            fc_reg    <= fc_next;
            limit_reg <= limit_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_SLOT_LIMIT)
                    ? APB_DATA_W'(limit_reg) : '0;

endmodule

[hdl/hsa_checker.sv]
// Port-level checker for the handle slot allocator, bound to the top level.
// Depends on hsa_pkg for the result struct and status codes.
`timescale 1ns / 1ps

module hsa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input hsa_pkg::hsa_rsp_t rsp
);
    import hsa_pkg::*;

    // An accepted transaction makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted command");

    // Every accepted transaction produces its result after passing through the work state and the done register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result missing two cycles after acceptance");

    // A result is shown only while no command is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A failed command never returns an object reference.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == STAT_FULL || rsp.status == STAT_RANGE))
            |-> (rsp.object_out == '0))
        else $error("nonzero object on a failed command");

endmodule

bind handle_slot_allocator_unit hsa_checker u_hsa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
